>>> hw/rtl/rolling_median_outlier_estimator_top_defines.svh
`ifndef ROLLING_MEDIAN_OUTLIER_ESTIMATOR_TOP_DEFINES_SVH
`define ROLLING_MEDIAN_OUTLIER_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RMOE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmoe check failed");

// Next-cycle implication, checked out of reset.
`define RMOE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmoe check failed");

`endif

>>> hw/rtl/rmoe_pkg.sv
`default_nettype none

package rmoe_pkg;

    localparam int MAX_WINDOW_DEF = 16;

    localparam int VAL_W   = 32;
    localparam int STAMP_W = 32;
    localparam int LEN_W   = 5;
    localparam int LIFE_W  = 32;
    localparam int THR_W   = 31;
    localparam int CFG_W   = 32;
    localparam int EST_W   = 33;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CFG_NORM_LEN = 2'd0;
    localparam logic [1:0] CFG_LL_LEN   = 2'd1;
    localparam logic [1:0] CFG_LIFE     = 2'd2;
    localparam logic [1:0] CFG_THR      = 2'd3;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPACT,
        S_MED,
        S_SCAN,
        S_CHK,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // window cell control
    typedef struct packed {
        logic shift;
        logic wr;
    } t_wctl;

    // sorted cell control
    typedef struct packed {
        logic clr;
        logic ins;
        logic rot;
    } t_sctl;

endpackage

`default_nettype wire

>>> hw/rtl/rmoe_wcell.sv
`default_nettype none

module rmoe_wcell
    import rmoe_pkg::*;
(
    input  wire logic   i_clk,
    input  wire t_wctl  i_ctl,
    input  wire t_entry i_right,
    input  wire t_entry i_new,
    output t_entry      o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_right;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> hw/rtl/rmoe_scell.sv
`default_nettype none

module rmoe_scell
    import rmoe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_sctl            i_ctl,
    input  wire logic [VAL_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_left_val,
    input  wire logic             i_left_vld,
    input  wire logic             i_left_gt,
    input  wire logic [VAL_W-1:0] i_right_val,
    input  wire logic             i_right_vld,
    output logic [VAL_W-1:0]      o_val,
    output logic                  o_vld,
    output logic                  o_gt
);

    logic [VAL_W-1:0] r_val;
    logic             r_vld;
    logic             take_key;

    assign o_gt     = r_vld && (r_val > i_key);
    // first slot past the smaller-or-equal prefix takes the key
    assign take_key = !i_left_gt && (r_vld ? (r_val > i_key) : i_left_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                r_val <= i_left_val;
                r_vld <= 1'b1;
            end else if (take_key) begin
                r_val <= i_key;
                r_vld <= 1'b1;
            end
        end else if (i_ctl.rot) begin
            r_val <= i_right_val;
            r_vld <= i_right_vld;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

`default_nettype wire

>>> hw/rtl/rmoe_div.sv
`default_nettype none

module rmoe_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

>>> hw/rtl/rolling_median_outlier_estimator_top.sv
// Channel   Signals                                           Handshake
// command   i_op i_sample_bps i_low_latency i_now_ms          start && !busy
// result    o_estimate_bps                                    o_est_valid, one cycle
// config    i_cfg_idx i_cfg_data                              i_cfg_we
//
// Add and clear complete without raising busy. A query holds busy through
// one compaction step per stored entry, a rotation of the sorted cell row to
// the median and once around for the outlier sum, then a bit-serial divider.
// A window that is empty after compaction ends the query there, as does an
// outlier sum with no entry kept. The estimate strobes in the first cycle after busy drops.
// Reset empties the window; results cannot be stalled by the receiver.
`default_nettype none

`include "rolling_median_outlier_estimator_top_defines.svh"

module rolling_median_outlier_estimator_top
    import rmoe_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_op,
    input  wire logic [VAL_W-1:0]   i_sample_bps,
    input  wire logic               i_low_latency,
    input  wire logic [STAMP_W-1:0] i_now_ms,
    output logic                    o_est_valid,
    output logic signed [EST_W-1:0] o_estimate_bps,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = VAL_W + CNT_W;
    localparam int CMP_W = CNT_W + LEN_W;

    // configuration
    logic [LEN_W-1:0]  r_norm_len;
    logic [LEN_W-1:0]  r_ll_len;
    logic [LIFE_W-1:0] r_life;
    logic [THR_W-1:0]  r_thr;

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_kept;
    logic [SUM_W-1:0]   r_sum;
    logic [VAL_W-1:0]   r_lo;
    logic [VAL_W-1:0]   r_med;
    logic [STAMP_W-1:0] r_now;
    logic               r_res_vld;
    logic [EST_W-1:0]   r_res;

    // cell rows
    t_entry           w_ent [MAX_WINDOW];
    t_wctl            w_ctl [MAX_WINDOW];
    logic [VAL_W-1:0] s_val [MAX_WINDOW];
    logic             s_vld [MAX_WINDOW];
    logic             s_gt  [MAX_WINDOW];
    t_sctl            s_ctl;
    t_entry           new_ent;
    logic             w_shift;
    logic             w_wr_en;
    logic [CNT_W-1:0] w_pos;

    logic              accept;
    logic [LEN_W-1:0]  lim_sel;
    logic [CMP_W-1:0]  lim_cap;
    logic              drop_add;
    logic              add_wr;
    logic signed [STAMP_W:0] age;
    logic              keep;
    logic [CNT_W-1:0]  n_half;
    logic [VAL_W:0]    pair_sum;
    logic signed [VAL_W+1:0] diff;
    logic signed [VAL_W+1:0] dev;
    logic              take;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // add path
    assign lim_sel  = i_low_latency ? r_ll_len : r_norm_len;
    assign lim_cap  = (CMP_W'(lim_sel) > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW)
                                                             : CMP_W'(lim_sel);
    assign drop_add = (r_count == CNT_W'(MAX_WINDOW)) ||
                      ((CMP_W'(r_count) + CMP_W'(1)) > lim_cap);
    assign add_wr   = !((r_count == '0) && drop_add);

    // compaction on the head cell
    assign age  = $signed({1'b0, r_now}) - $signed({1'b0, w_ent[0].stamp});
    assign keep = (w_ent[0].stamp != '0) && !(age > $signed({1'b0, r_life}));

    // median and distance
    assign n_half   = r_n >> 1;
    assign pair_sum = {1'b0, r_lo} + {1'b0, s_val[0]};
    assign diff     = $signed({2'b0, s_val[0]}) - $signed({2'b0, r_med});
    assign dev      = ((r_n != CNT_W'(2)) && (diff < 0)) ? -diff : diff;
    assign take     = s_vld[0] && !(dev > $signed({3'b0, r_thr}));

    always_comb begin
        n_state   = r_state;
        w_shift   = 1'b0;
        w_wr_en   = 1'b0;
        w_pos     = '0;
        new_ent   = w_ent[0];
        s_ctl     = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                new_ent.value = i_sample_bps;
                new_ent.stamp = i_now_ms;
                if (accept) begin
                    unique case (i_op)
                        OP_ADD: begin
                            w_shift = drop_add;
                            w_wr_en = add_wr;
                            w_pos   = r_count - CNT_W'(drop_add);
                        end
                        OP_QUERY: begin
                            s_ctl.clr = 1'b1;
                            n_state   = S_COMPACT;
                        end
                        default: ;
                    endcase
                end
            end
            S_COMPACT: begin
                if (r_k == r_count) begin
                    n_state = (r_n == '0) ? S_IDLE : S_MED;
                end else begin
                    w_shift   = 1'b1;
                    w_wr_en   = keep;
                    w_pos     = r_count - r_k - CNT_W'(1) + r_n;
                    s_ctl.ins = keep;
                end
            end
            S_MED: begin
                s_ctl.rot = 1'b1;
                if (r_k == n_half) n_state = S_SCAN;
            end
            S_SCAN: begin
                s_ctl.rot = 1'b1;
                if (r_k == CNT_W'(MAX_WINDOW - 1)) n_state = S_CHK;
            end
            S_CHK: begin
                if (r_kept == '0) begin
                    n_state = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_len <= LEN_RESET;
            r_ll_len   <= LEN_RESET;
            r_life     <= '0;
            r_thr      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NORM_LEN: r_norm_len <= i_cfg_data[LEN_W-1:0];
                CFG_LL_LEN:   r_ll_len   <= i_cfg_data[LEN_W-1:0];
                CFG_LIFE:     r_life     <= i_cfg_data[LIFE_W-1:0];
                CFG_THR:      r_thr      <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_k       <= '0;
            r_n       <= '0;
            r_kept    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_op)
                            OP_ADD: begin
                                r_count <= r_count + CNT_W'(1) - CNT_W'(drop_add);
                            end
                            OP_QUERY: begin
                                r_k   <= '0;
                                r_n   <= '0;
                                r_now <= i_now_ms;
                            end
                            OP_CLEAR: r_count <= '0;
                            default: ;
                        endcase
                    end
                end
                S_COMPACT: begin
                    if (r_k == r_count) begin
                        r_count <= r_n;
                        r_k     <= '0;
                        if (r_n == '0) begin
                            r_res_vld <= 1'b1;
                            r_res     <= '1;
                        end
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                        if (keep) r_n <= r_n + CNT_W'(1);
                    end
                end
                S_MED: begin
                    if (!r_n[0] && (r_k == n_half - CNT_W'(1))) r_lo <= s_val[0];
                    if (r_k == n_half) begin
                        r_med  <= r_n[0] ? s_val[0] : pair_sum[VAL_W:1];
                        r_k    <= '0;
                        r_sum  <= '0;
                        r_kept <= '0;
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + CNT_W'(1);
                    if (take) begin
                        r_sum  <= r_sum + SUM_W'(s_val[0]);
                        r_kept <= r_kept + CNT_W'(1);
                    end
                end
                S_CHK: begin
                    if (r_kept == '0) begin
                        r_res_vld <= 1'b1;
                        r_res     <= '1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res_vld <= 1'b1;
                        r_res     <= {1'b0, div_quo[VAL_W-1:0]};
                    end
                end
                default: ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            localparam int RI = (gi == MAX_WINDOW - 1) ? 0 : gi + 1;
            localparam int LI = (gi == 0) ? 0 : gi - 1;

            assign w_ctl[gi].shift = w_shift;
            assign w_ctl[gi].wr    = w_wr_en && (w_pos == CNT_W'(gi));

            rmoe_wcell u_wcell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[gi]),
                .i_right (w_ent[RI]),
                .i_new   (new_ent),
                .o_entry (w_ent[gi])
            );

            rmoe_scell u_scell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (s_ctl),
                .i_key       (w_ent[0].value),
                .i_left_val  (s_val[LI]),
                .i_left_vld  ((gi == 0) ? 1'b1 : s_vld[LI]),
                .i_left_gt   ((gi == 0) ? 1'b0 : s_gt[LI]),
                .i_right_val (s_val[RI]),
                .i_right_vld (s_vld[RI]),
                .o_val       (s_val[gi]),
                .o_vld       (s_vld[gi]),
                .o_gt        (s_gt[gi])
            );
        end
    endgenerate

    rmoe_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_kept),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_est_valid    = r_res_vld;
    assign o_estimate_bps = $signed(r_res);

    `RMOE_ASSERT_IMP(a_res_idle, o_est_valid, !busy)
    `RMOE_ASSERT_NXT(a_query_busy, accept && (i_op == OP_QUERY), busy)
    `RMOE_ASSERT_NXT(a_add_quick, accept && (i_op != OP_QUERY), !busy && !o_est_valid)
    `RMOE_ASSERT_IMP(a_count_max, busy || !busy, r_count <= CNT_W'(MAX_WINDOW))

endmodule

`default_nettype wire
